>>> rtl/mtep_pkg.sv
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and codes of the track event parser: channel words, queue
// entry, result kinds, error codes and register map.
// ----------------------------------------------------------------------------
package mtep_pkg;

	localparam int VARLEN_MAX_BYTES_DEF = 4;
	localparam int QUEUE_DEPTH_DEF      = 2;

	localparam int DELTA_W = 28;
	localparam int LEN_W   = 17;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 17'h10000;

	// result kinds
	localparam logic [2:0] KIND_CHANNEL = 3'd0;
	localparam logic [2:0] KIND_SYSEX   = 3'd1;
	localparam logic [2:0] KIND_META    = 3'd2;
	localparam logic [2:0] KIND_PAYLOAD = 3'd3;
	localparam logic [2:0] KIND_ERROR   = 3'd4;

	// error codes
	localparam logic [1:0] ERR_STREAM_END = 2'd0;
	localparam logic [1:0] ERR_LEN_FIELD  = 2'd1;
	localparam logic [1:0] ERR_PAYLOAD    = 2'd2;
	localparam logic [1:0] ERR_STATUS     = 2'd3;

	// register map (register index taken from paddr[2])
	localparam logic REG_MAX_PAYLOAD_LENGTH = 1'b0;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_end;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         result_kind;
		logic [7:0]         status_code;
		logic [3:0]         channel_number;
		logic [7:0]         first_param;
		logic [7:0]         second_param;
		logic [DELTA_W-1:0] delta_ticks;
		logic [LEN_W-1:0]   payload_length;
		logic [7:0]         meta_kind;
		logic [7:0]         payload_value;
		logic [1:0]         error_code;
		logic               last;
	} out_item_t;

	// compact word between front and back
	typedef struct packed {
		logic [2:0]         kind;
		logic [7:0]         status;
		logic [7:0]         p1;
		logic [7:0]         p2;
		logic [DELTA_W-1:0] delta;
		logic [LEN_W-1:0]   len;
		logic [7:0]         meta;
		logic [1:0]         err;
		logic               last;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t entry;
	} push_t;

	typedef struct packed {
		logic   valid;
		logic   full;
		entry_t entry;
	} queue_status_t;

endpackage

>>> rtl/mtep_front.sv
// ----------------------------------------------------------------------------
// mtep_front
// Byte decoder: accepts track bytes, runs the event state machine and pushes
// one compact word per result into the queue.
// ----------------------------------------------------------------------------
module mtep_front #(
	parameter int VARLEN_MAX_BYTES = mtep_pkg::VARLEN_MAX_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       acc,
	input  mtep_pkg::in_item_t         item,
	input  logic [mtep_pkg::LEN_W-1:0] max_len,
	output mtep_pkg::push_t            push,
	output logic                       halted
);

	localparam int CNT_W = $clog2(VARLEN_MAX_BYTES + 1);

	typedef enum logic [7:0] {
		PH_DELTA     = 8'b0000_0001,
		PH_STATUS    = 8'b0000_0010,
		PH_PARAM1    = 8'b0000_0100,
		PH_PARAM2    = 8'b0000_1000,
		PH_SX_LEN    = 8'b0001_0000,
		PH_META_TYPE = 8'b0010_0000,
		PH_META_LEN  = 8'b0100_0000,
		PH_PAYLOAD   = 8'b1000_0000
	} phase_t;

	phase_t                        phase_q, phase_d;
	logic [mtep_pkg::DELTA_W-1:0]  accum_q, accum_d;
	logic [CNT_W-1:0]              count_q, count_d;
	logic [7:0]                    status_q, status_d;
	logic [7:0]                    param_q, param_d;
	logic [mtep_pkg::DELTA_W-1:0]  delta_q, delta_d;
	logic [7:0]                    meta_q, meta_d;
	logic [mtep_pkg::LEN_W-1:0]    rem_q, rem_d;
	logic                          halted_q, halted_d;

	logic [7:0]                    b;
	logic [mtep_pkg::DELTA_W-1:0]  vl_accum;
	logic [CNT_W-1:0]              vl_count;
	logic                          vl_done;
	logic                          vl_long;
	logic [mtep_pkg::LEN_W-1:0]    rem_dec;
	mtep_pkg::entry_t              e;
	logic                          emit;

	assign b        = item.data_byte;
	assign vl_accum = {accum_q[mtep_pkg::DELTA_W-8:0], b[6:0]};
	assign vl_count = count_q + 1'b1;
	assign vl_done  = !b[7];
	assign vl_long  = b[7] && (vl_count >= CNT_W'(VARLEN_MAX_BYTES));
	assign rem_dec  = rem_q - 1'b1;

	always_comb begin
		phase_d  = phase_q;
		accum_d  = accum_q;
		count_d  = count_q;
		status_d = status_q;
		param_d  = param_q;
		delta_d  = delta_q;
		meta_d   = meta_q;
		rem_d    = rem_q;
		halted_d = halted_q;
		emit     = 1'b0;
		e        = '0;
		if (acc && !halted_q) begin
			if (item.stream_end) begin
				// end of data between events is quiet
				if (!(phase_q == PH_DELTA && count_q == '0)) begin
					emit     = 1'b1;
					e.kind   = mtep_pkg::KIND_ERROR;
					e.err    = mtep_pkg::ERR_STREAM_END;
					e.last   = 1'b1;
					halted_d = 1'b1;
				end
			end else begin
				case (phase_q)
					PH_DELTA: begin
						accum_d = vl_accum;
						count_d = vl_count;
						if (vl_done) begin
							delta_d = vl_accum;
							accum_d = '0;
							count_d = '0;
							phase_d = PH_STATUS;
						end else if (vl_long) begin
							emit     = 1'b1;
							e.kind   = mtep_pkg::KIND_ERROR;
							e.err    = mtep_pkg::ERR_LEN_FIELD;
							e.last   = 1'b1;
							halted_d = 1'b1;
						end
					end
					PH_STATUS: begin
						status_d = b;
						if (b[7] && b[7:4] != 4'hf) begin
							phase_d = PH_PARAM1;
						end else if (b == 8'hf0 || b == 8'hf7) begin
							phase_d = PH_SX_LEN;
						end else if (b == 8'hff) begin
							phase_d = PH_META_TYPE;
						end else begin
							emit     = 1'b1;
							e.kind   = mtep_pkg::KIND_ERROR;
							e.err    = mtep_pkg::ERR_STATUS;
							e.last   = 1'b1;
							halted_d = 1'b1;
						end
					end
					PH_PARAM1: begin
						if (status_q[7:4] == 4'hc || status_q[7:4] == 4'hd) begin
							emit     = 1'b1;
							e.kind   = mtep_pkg::KIND_CHANNEL;
							e.status = status_q;
							e.p1     = b;
							e.delta  = delta_q;
							e.last   = 1'b1;
							phase_d  = PH_DELTA;
						end else begin
							param_d = b;
							phase_d = PH_PARAM2;
						end
					end
					PH_PARAM2: begin
						emit     = 1'b1;
						e.kind   = mtep_pkg::KIND_CHANNEL;
						e.status = status_q;
						e.p1     = param_q;
						e.p2     = b;
						e.delta  = delta_q;
						e.last   = 1'b1;
						phase_d  = PH_DELTA;
					end
					PH_META_TYPE: begin
						meta_d  = b;
						phase_d = PH_META_LEN;
					end
					PH_SX_LEN, PH_META_LEN: begin
						accum_d = vl_accum;
						count_d = vl_count;
						if (vl_done) begin
							accum_d = '0;
							count_d = '0;
							emit    = 1'b1;
							if (vl_accum > {{(mtep_pkg::DELTA_W-mtep_pkg::LEN_W){1'b0}}, max_len})
							begin
								e.kind   = mtep_pkg::KIND_ERROR;
								e.err    = mtep_pkg::ERR_PAYLOAD;
								e.last   = 1'b1;
								halted_d = 1'b1;
							end else begin
								rem_d    = vl_accum[mtep_pkg::LEN_W-1:0];
								e.kind   = (phase_q == PH_SX_LEN) ? mtep_pkg::KIND_SYSEX
								                                  : mtep_pkg::KIND_META;
								e.status = status_q;
								e.delta  = delta_q;
								e.len    = vl_accum[mtep_pkg::LEN_W-1:0];
								e.meta   = meta_q;
								e.last   = (vl_accum[mtep_pkg::LEN_W-1:0] == '0);
								phase_d  = (vl_accum[mtep_pkg::LEN_W-1:0] == '0) ? PH_DELTA
								                                                 : PH_PAYLOAD;
							end
						end else if (vl_long) begin
							emit     = 1'b1;
							e.kind   = mtep_pkg::KIND_ERROR;
							e.err    = mtep_pkg::ERR_LEN_FIELD;
							e.last   = 1'b1;
							halted_d = 1'b1;
						end
					end
					PH_PAYLOAD: begin
						emit   = 1'b1;
						e.kind = mtep_pkg::KIND_PAYLOAD;
						e.p1   = b;
						e.last = (rem_dec == '0);
						rem_d  = rem_dec;
						if (rem_dec == '0) begin
							phase_d = PH_DELTA;
						end
					end
					default: begin
						phase_d = PH_DELTA;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_DELTA;
			accum_q  <= '0;
			count_q  <= '0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			accum_q  <= accum_d;
			count_q  <= count_d;
			halted_q <= halted_d;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		param_q  <= param_d;
		delta_q  <= delta_d;
		meta_q   <= meta_d;
		rem_q    <= rem_d;
	end

	assign push.push  = emit;
	assign push.entry = e;
	assign halted     = halted_q;

endmodule

>>> rtl/mtep_queue.sv
// ----------------------------------------------------------------------------
// mtep_queue
// Small fifo of decoded words between the byte decoder and the result stage.
// ----------------------------------------------------------------------------
module mtep_queue #(
	parameter int DEPTH = mtep_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mtep_pkg::push_t         push,
	input  logic                    pop,
	output mtep_pkg::queue_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mtep_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign do_push = push.push;
	assign do_pop  = pop && (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	assign status.valid = (cnt_q != '0);
	assign status.full  = (cnt_q == CNT_W'(DEPTH));
	assign status.entry = mem_q[rd_ptr_q];

endmodule

>>> rtl/mtep_back.sv
// ----------------------------------------------------------------------------
// mtep_back
// Result stage: expands queued words into result words and holds them in the
// output register until taken.
// ----------------------------------------------------------------------------
module mtep_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mtep_pkg::queue_status_t qs,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output mtep_pkg::out_item_t     out_data
);

	logic                out_valid_q;
	mtep_pkg::out_item_t out_data_q;
	mtep_pkg::out_item_t r;
	mtep_pkg::entry_t    e;

	assign e   = qs.entry;
	assign pop = qs.valid && (!out_valid_q || out_ready);

	always_comb begin
		r             = '0;
		r.result_kind = e.kind;
		r.last        = e.last;
		case (e.kind)
			mtep_pkg::KIND_CHANNEL: begin
				r.status_code    = {4'h0, e.status[7:4]};
				r.channel_number = e.status[3:0];
				r.first_param    = e.p1;
				r.second_param   = e.p2;
				r.delta_ticks    = e.delta;
			end
			mtep_pkg::KIND_SYSEX: begin
				r.status_code    = e.status;
				r.delta_ticks    = e.delta;
				r.payload_length = e.len;
			end
			mtep_pkg::KIND_META: begin
				r.status_code    = e.status;
				r.delta_ticks    = e.delta;
				r.payload_length = e.len;
				r.meta_kind      = e.meta;
			end
			mtep_pkg::KIND_PAYLOAD: begin
				r.payload_value = e.p1;
			end
			mtep_pkg::KIND_ERROR: begin
				r.error_code = e.err;
			end
			default: begin
				r = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= r;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> rtl/midi_track_event_parser.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Track event parser for standard MIDI file track data, one byte per word.
// ----------------------------------------------------------------------------
// One byte is accepted every clock cycle while the queue is not full, whether
// or not it completes a result; the byte decoder state machine settles each
// byte as it is accepted. Results pass through a queue of QUEUE_DEPTH words
// and an output register, so a result is registered in the queue and then in
// the output register before it is presented, and in_ready falls only when
// the queue is full because the result side is stalled.
// After an error result the block keeps taking bytes and drops them until
// reset. The payload length limit is written over the APB port at address 0.
module midi_track_event_parser #(
	parameter int VARLEN_MAX_BYTES = mtep_pkg::VARLEN_MAX_BYTES_DEF,
	parameter int QUEUE_DEPTH      = mtep_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mtep_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mtep_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [mtep_pkg::LEN_W-1:0] max_len_q;
	logic                       acc;
	logic                       halted;
	logic                       pop;
	mtep_pkg::push_t            push;
	mtep_pkg::queue_status_t    qs;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= mtep_pkg::MAX_LEN_RESET;
		end else if (psel && penable && pwrite && paddr[2] == mtep_pkg::REG_MAX_PAYLOAD_LENGTH)
		begin
			max_len_q <= pwdata[mtep_pkg::LEN_W-1:0];
		end
	end

	assign prdata = (paddr[2] == mtep_pkg::REG_MAX_PAYLOAD_LENGTH)
	              ? {{(32-mtep_pkg::LEN_W){1'b0}}, max_len_q} : '0;

	assign in_ready = !qs.full;
	assign acc      = in_valid && in_ready;

	mtep_front #(
		.VARLEN_MAX_BYTES(VARLEN_MAX_BYTES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.item   (in_data),
		.max_len(max_len_q),
		.push   (push),
		.halted (halted)
	);

	mtep_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.status(qs)
	);

	mtep_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qs       (qs),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.push && qs.full))
		else $error("push into full queue");

	// a halted decoder never emits
	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		halted |-> !push.push)
		else $error("result emitted while halted");

	// halt holds until reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted |=> halted)
		else $error("halt released without reset");

	// every error word closes its event and halts the decoder
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.push && push.entry.kind == mtep_pkg::KIND_ERROR |=> halted)
		else $error("error did not halt");

endmodule
